// ----- design/ibd_pkg.sv -----
// Shared constants and types for the interleaved box decimator.
package ibd_pkg;

  localparam int SampleW  = 16;
  localparam int ByteW    = 8;
  localparam int FactorW  = 4;
  localparam int ChanCntW = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam int DefMaxFactorLog2 = 8;
  localparam int DefMaxChannels   = 2;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgFactorLog2   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChannelCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSampleIsWide = 2'd2;

  localparam logic [FactorW-1:0]  RstFactorLog2   = 4'd1;
  localparam logic [ChanCntW-1:0] RstChannelCount = 2'd1;
  localparam logic                RstSampleIsWide = 1'b1;

  typedef struct packed {
    logic [FactorW-1:0]  factor_log2;
    logic [ChanCntW-1:0] channel_count;
    logic                sample_is_wide;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [SampleW-1:0] average;
    logic                      channel;
  } result_t;

endpackage

// ----- design/ibd_if.sv -----
// Stream and config channel interfaces of the interleaved box decimator.
interface ibd_in_if import ibd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_in;
  logic                      end_of_block;

  modport source (output valid, output sample_in, output end_of_block, input ready);
  modport sink   (input valid, input sample_in, input end_of_block, output ready);
endinterface

interface ibd_out_if import ibd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] average_out;
  logic                      channel_index;

  modport source (output valid, output average_out, output channel_index, input ready);
  modport sink   (input valid, input average_out, input channel_index, output ready);
endinterface

interface ibd_cfg_if import ibd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/interleaved_box_decimator_top.sv -----
// Interleaved boxcar averaging decimator, top level.
//
// Usage:
//   in_i   : one interleaved PCM sample per word plus an end-of-block flag.
//   out_o  : one averaged sample per word, tagged with its channel.
//   cfg_i  : register writes (index 0 factor_log2, 1 channel_count,
//            2 sample_is_wide); always ready, write only while idle.
// A word that closes a group for its channel yields that channel's average
// (sum >> factor_log2, truncated toward zero); other words yield nothing.
// End of block drops a partial group and restarts at channel 0, frame 0.
// Timing: the accept edge loads the input register, and the result register is
// written at the edge on which the word leaves the input register.
// Throughput: one word per cycle while results are taken; the read-add-write
// of the current channel's sum is combinational, so words follow back to back.
// Reset: sums and phases clear, registers return to factor_log2 1, mono, 16-bit.
// Receiver stall: the result register holds; the input register still
// moves words that produce no result only once the result slot frees,
// so in_i.ready drops after one more word is taken.
module interleaved_box_decimator_top import ibd_pkg::*; #(
  parameter int MaxFactorLog2 = DefMaxFactorLog2,
  parameter int MaxChannels   = DefMaxChannels
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ibd_in_if.sink   in_i,
  ibd_out_if.source out_o,
  ibd_cfg_if.sink  cfg_i
);

  cfg_t    cfg;
  result_t res;

  // input register
  logic                      s1_valid_q;
  logic signed [SampleW-1:0] s1_sample_q;
  logic                      s1_eob_q;

  // result register
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_avg_q;
  logic                      out_ch_q;

  logic advance;
  logic in_fire;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  ibd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid && cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // a word leaves the input register when the result slot is free or draining
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= in_i.sample_in;
      s1_eob_q    <= in_i.end_of_block;
    end
  end

  ibd_accum #(
    .MaxFactorLog2 (MaxFactorLog2),
    .MaxChannels   (MaxChannels)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (advance),
    .sample_i (s1_sample_q),
    .eob_i    (s1_eob_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_avg_q <= res.average;
      out_ch_q  <= res.channel;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.average_out   = out_avg_q;
  assign out_o.channel_index = out_ch_q;

`ifndef NO_ASSERTIONS
  // input stalls only when a word waits behind an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  // a held word in the input register is not lost or altered
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_sample_q)
                                  && $stable(s1_eob_q)))
    else $error("input register word dropped while stalled");

  // a new result only appears after a word moved through the accumulator
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!advance && !(out_valid_q && !out_o.ready)) |=> !out_valid_q)
    else $error("result appeared without an accumulate step");
`endif

endmodule

// ----- design/ibd_cfg_regs.sv -----
// Configuration registers of the interleaved box decimator.
module ibd_cfg_regs import ibd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.factor_log2    <= RstFactorLog2;
      cfg_q.channel_count  <= RstChannelCount;
      cfg_q.sample_is_wide <= RstSampleIsWide;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CfgFactorLog2:   cfg_q.factor_log2    <= wr_data_i[FactorW-1:0];
        CfgChannelCount: cfg_q.channel_count  <= wr_data_i[ChanCntW-1:0];
        CfgSampleIsWide: cfg_q.sample_is_wide <= wr_data_i[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/ibd_accum.sv -----
// Per-channel running sums, frame/channel phase and the average of a closed group.
module ibd_accum import ibd_pkg::*; #(
  parameter int MaxFactorLog2 = DefMaxFactorLog2,
  parameter int MaxChannels   = DefMaxChannels
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      fire_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      eob_i,
  output result_t                   result_o
);

  localparam int SumW = SampleW + MaxFactorLog2 + 1;  // one guard bit
  localparam int FpW  = MaxFactorLog2;
  localparam int LgW  = $clog2(MaxFactorLog2 + 1);
  localparam int ChW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  logic signed [SumW-1:0] sums_q [MaxChannels];
  logic [FpW-1:0]         frame_q;
  logic [ChW-1:0]         chan_q;

  logic [LgW-1:0]         lg;
  logic [ChW-1:0]         last_ch;
  logic [ChW-1:0]         ch;
  logic signed [SumW-1:0] sample_ext;
  logic signed [SumW-1:0] sum_new;
  logic [FpW:0]           factor_m1;
  logic                   last_frame;
  logic                   last_channel;
  logic [SumW-1:0]        round_mask;
  logic signed [SumW-1:0] sum_adj;
  logic signed [SumW-1:0] quot;

  // clamp factor to 1..MaxFactorLog2
  always_comb begin
    int f;
    f = int'(cfg_i.factor_log2);
    if (f < 1) f = 1;
    if (f > MaxFactorLog2) f = MaxFactorLog2;
    lg = LgW'(f);
  end

  // clamp channel count to 1..MaxChannels, keep last index
  always_comb begin
    int c;
    c = int'(cfg_i.channel_count);
    if (c < 1) c = 1;
    if (c > MaxChannels) c = MaxChannels;
    last_ch = ChW'(c - 1);
  end

  assign ch = (chan_q >= last_ch) ? last_ch : chan_q;

  assign sample_ext = cfg_i.sample_is_wide
                    ? {{(SumW-SampleW){sample_i[SampleW-1]}}, sample_i}
                    : {{(SumW-ByteW){1'b0}}, sample_i[ByteW-1:0]};

  assign sum_new = sums_q[ch] + sample_ext;

  assign factor_m1    = ({{FpW{1'b0}}, 1'b1} << lg) - {{FpW{1'b0}}, 1'b1};
  assign last_frame   = {1'b0, frame_q} >= factor_m1;
  assign last_channel = (ch == last_ch);

  // truncate toward zero: bias negatives by factor - 1 before the shift
  assign round_mask = (SumW'(1) << lg) - SumW'(1);
  assign sum_adj    = sum_new + (sum_new[SumW-1] ? $signed(round_mask) : '0);
  assign quot       = sum_adj >>> lg;

  assign result_o.valid   = fire_i && last_frame;
  assign result_o.average = quot[SampleW-1:0];
  assign result_o.channel = ch[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxChannels; i++) sums_q[i] <= '0;
      frame_q <= '0;
      chan_q  <= '0;
    end else if (fire_i) begin
      if (eob_i) begin
        for (int i = 0; i < MaxChannels; i++) sums_q[i] <= '0;
        frame_q <= '0;
        chan_q  <= '0;
      end else begin
        sums_q[ch] <= last_frame ? '0 : sum_new;
        if (last_channel) begin
          chan_q  <= '0;
          frame_q <= last_frame ? '0 : frame_q + 1'b1;
        end else begin
          chan_q <= ch + 1'b1;
        end
      end
    end
  end

endmodule

// ----- sim/interleaved_box_decimator_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the interleaved box decimator top level.
module interleaved_box_decimator_top_tb;
  import ibd_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int DrainCycles = 8;     // leave margin before config writes
  localparam int HoldAt = 150;        // accepted words before the long receiver hold
  localparam int HoldCycles = 300;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      eob;
  } in_word_t;

  typedef struct {
    logic signed [SampleW-1:0] average;
    logic                      channel;
  } avg_word_t;

  logic clk;
  logic rst_n;

  ibd_in_if  in_if ();
  ibd_out_if out_if ();
  ibd_cfg_if cfg_if ();

  interleaved_box_decimator_top u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // words waiting to be driven, averages waiting to come out
  in_word_t  words_to_send[$];
  avg_word_t averages_due[$];

  int  n_queued;
  int  n_taken;
  int  n_errors;
  int  idle_pct;        // per-phase odds of starting an idle burst, 0 = none
  int  src_gap;
  int  snk_gap;
  bit  long_hold;
  bit  in_took;         // input word accepted at the last rising edge
  in_word_t next_word;

  // shadow of the registers and of the accumulator state
  logic [FactorW-1:0]  cfg_factor;
  logic [ChanCntW-1:0] cfg_chans;
  logic                cfg_wide;
  longint              chan_sum[DefMaxChannels];
  int                  frame_ph;
  int                  chan_ph;

  initial clk = 1'b0;
  always #HalfPeriod clk = ~clk;

  // Accumulate one sample and queue the average it closes, if any.
  task automatic accumulate_sample(input logic [SampleW-1:0] raw, input logic eob);
    int        lg;
    int        nch;
    int        factor;
    int        ch;
    longint    smp;
    longint    avg;
    bit        closing;
    avg_word_t e;
    lg = int'(cfg_factor);
    if (lg < 1) lg = 1;
    if (lg > DefMaxFactorLog2) lg = DefMaxFactorLog2;
    nch = int'(cfg_chans);
    if (nch < 1) nch = 1;
    if (nch > DefMaxChannels) nch = DefMaxChannels;
    factor = 1 << lg;
    if (cfg_wide) smp = longint'($signed(raw));
    else smp = longint'(raw[ByteW-1:0]);
    // a phase past the new last position counts as the last one
    ch = (chan_ph >= nch) ? nch - 1 : chan_ph;
    chan_sum[ch] += smp;
    closing = frame_ph >= factor - 1;
    if (closing) begin
      avg = chan_sum[ch] / longint'(factor);   // truncates toward zero
      e.average = avg[SampleW-1:0];
      e.channel = ch[0];
      averages_due.push_back(e);
      chan_sum[ch] = 0;
    end
    if (ch >= nch - 1) begin
      chan_ph = 0;
      frame_ph = closing ? 0 : frame_ph + 1;
    end else begin
      chan_ph = ch + 1;
    end
    if (eob) begin
      foreach (chan_sum[i]) chan_sum[i] = 0;
      frame_ph = 0;
      chan_ph = 0;
    end
  endtask

  // Input side: prediction happens at the accepting edge.
  always @(posedge clk) begin
    in_took = rst_n && in_if.valid && in_if.ready;
    if (in_took) begin
      accumulate_sample(in_if.sample_in, in_if.end_of_block);
      n_taken++;
    end
  end

  // Driver: changes on the falling edge, holds a word until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid        <= 1'b0;
      in_if.sample_in    <= '0;
      in_if.end_of_block <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (words_to_send.size() > 0 && idle_pct > 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        src_gap = $urandom_range(0, 17);   // this cycle is the first idle one
        in_if.valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        next_word = words_to_send.pop_front();
        in_if.valid        <= 1'b1;
        in_if.sample_in    <= next_word.sample;
        in_if.end_of_block <= next_word.eob;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver readiness: random stall bursts plus one long hold.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_hold) begin
      out_if.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_if.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      snk_gap = $urandom_range(0, 17);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Long receiver hold while the sender keeps offering: fills the pipe and
  // must back-pressure the input.
  initial begin
    long_hold = 1'b0;
    wait (n_taken >= HoldAt);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    long_hold = 1'b0;
  end

  // Monitor: each average word against the oldest expectation.
  always @(posedge clk) begin
    avg_word_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (averages_due.size() == 0) begin
        $display("%0t: unexpected average word, expected none, got avg %0d ch %0d",
                 $time, out_if.average_out, out_if.channel_index);
        n_errors++;
      end else begin
        e = averages_due.pop_front();
        if (out_if.average_out !== e.average) begin
          $display("%0t: average mismatch, expected %0d, got %0d",
                   $time, e.average, out_if.average_out);
          n_errors++;
        end
        if (out_if.channel_index !== e.channel) begin
          $display("%0t: channel mismatch, expected %0d, got %0d",
                   $time, e.channel, out_if.channel_index);
          n_errors++;
        end
      end
    end
  end

  task automatic push_word(input logic [SampleW-1:0] s, input logic eob);
    in_word_t w;
    w.sample = s;
    w.eob    = eob;
    words_to_send.push_back(w);
    n_queued++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CfgFactorLog2:   cfg_factor = data;
      CfgChannelCount: cfg_chans  = data[ChanCntW-1:0];
      CfgSampleIsWide: cfg_wide   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Wait until the block is idle, then write all three registers.
  // Unused upper data bits are randomized; the block must ignore them.
  task automatic configure(input logic [FactorW-1:0] f, input logic [ChanCntW-1:0] c,
                           input logic w);
    wait (n_taken == n_queued);
    wait (averages_due.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    write_reg(CfgFactorLog2, f);
    write_reg(CfgChannelCount, {2'($urandom), c});
    write_reg(CfgSampleIsWide, {3'($urandom), w});
  endtask

  task automatic run_phase(input logic [FactorW-1:0] f, input logic [ChanCntW-1:0] c,
                           input logic w, input int count, input int idle,
                           input int eob_pct);
    logic [SampleW-1:0] s;
    configure(f, c, w);
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 11))
        0:       s = 16'h7FFF;
        1:       s = 16'h8000;
        2:       s = 16'h0000;
        3:       s = 16'hFFFF;
        4:       s = 16'h00FF;
        default: s = 16'($urandom);
      endcase
      push_word(s, $urandom_range(0, 99) < eob_pct);
    end
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.sample_in    = '0;
    in_if.end_of_block = 1'b0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    cfg_factor = RstFactorLog2;
    cfg_chans  = RstChannelCount;
    cfg_wide   = RstSampleIsWide;
    foreach (chan_sum[i]) chan_sum[i] = 0;
    frame_ph = 0;
    chan_ph  = 0;
    n_queued = 0;
    n_taken  = 0;
    n_errors = 0;
    src_gap  = 0;
    snk_gap  = 0;
    in_took  = 1'b0;
    idle_pct = 15;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: factor 2, mono, signed 16-bit
    push_word(16'h7FFF, 1'b0); push_word(16'h7FFF, 1'b0);   // full scale positive
    push_word(16'h8000, 1'b0); push_word(16'h8000, 1'b0);   // full scale negative
    push_word(16'd1, 1'b0);    push_word(16'd0, 1'b0);
    push_word(16'hFFFF, 1'b0); push_word(16'd0, 1'b0);      // -1/2 rounds to 0
    push_word(-16'sd3, 1'b0);  push_word(16'd0, 1'b0);      // -3/2 rounds to -1
    push_word(16'd100, 1'b1);                               // end of block mid-group
    push_word(16'd5, 1'b0);    push_word(16'd7, 1'b0);
    push_word(16'h5555, 1'b0); push_word(16'hAAAA, 1'b0);
    push_word(16'd10, 1'b0);   push_word(16'd20, 1'b1);     // end of block on closing word

    // stereo: two full groups, then end of block between channels of a closing frame
    configure(4'd1, 2'd2, 1'b1);
    push_word(16'd1000, 1'b0); push_word(-16'sd1000, 1'b0);
    push_word(16'd3000, 1'b0); push_word(-16'sd3001, 1'b0);
    push_word(16'd7, 1'b0);    push_word(16'd9, 1'b0);
    push_word(16'd11, 1'b1);   // left average stands, right dropped

    // 8-bit mode: upper byte ignored
    configure(4'd1, 2'd1, 1'b0);
    push_word(16'hFFFF, 1'b0); push_word(16'h00FF, 1'b0);
    push_word(16'h8001, 1'b0); push_word(16'h0000, 1'b0);

    // random phases; register values below and above range included,
    // changes land mid-group so sums and phases carry over
    run_phase(4'd0,  2'd0, 1'b1, 300, 12, 3);   // long hold falls in here
    run_phase(4'd3,  2'd2, 1'b0, 300, 0,  2);
    run_phase(4'd12, 2'd3, 1'b1, 521, 10, 0);   // clamps to 256 frames, stereo
    run_phase(4'd2,  2'd1, 1'b1, 250, 20, 3);   // phases past the new end
    run_phase(4'd8,  2'd2, 1'b0, 60,  10, 0);
    run_phase(4'd1,  2'd2, 1'b1, 400, 0,  3);   // no idling at the end

    wait (n_taken == n_queued);
    wait (averages_due.size() == 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("[interleaved_box_decimator_top] OK");
    end else begin
      $display("[interleaved_box_decimator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[interleaved_box_decimator_top] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/ibd_pkg.sv
design/ibd_if.sv
design/ibd_cfg_regs.sv
design/ibd_accum.sv
design/interleaved_box_decimator_top.sv
sim/interleaved_box_decimator_top_tb.sv
